// ----- rtl/psu_pkg.sv -----
`timescale 1ns / 1ps

package psu_pkg;

  // Defaults of the top-level size parameters.
  localparam int unsigned MaxRowBytesDef   = 8192;
  localparam int unsigned MaxPixelBytesDef = 8;

  // Widths of the configuration registers and of the write port.
  localparam int unsigned RowBytesW   = 14;
  localparam int unsigned PixelBytesW = 4;
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned CfgDataW    = 14;

  // Register indexes.
  localparam logic [CfgIdxW-1:0] CFG_ROW_BYTES   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_PIXEL_BYTES = 2'd1;

  // Filter types of a scanline.
  typedef enum logic [2:0] {
    FILT_NONE    = 3'd0,
    FILT_SUB     = 3'd1,
    FILT_UP      = 3'd2,
    FILT_AVERAGE = 3'd3,
    FILT_PAETH   = 3'd4
  } filt_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       image_start;
  } in_t;

  typedef struct packed {
    logic [7:0] pixel_byte;
    logic       last_in_row;
    logic       error;
  } out_t;

endpackage

// ----- rtl/png_scanline_unfilter.sv -----
`timescale 1ns / 1ps

// PNG scanline reconstruction for filter types None, Sub, Up, Average and Paeth.
// Input channel (in_valid_i / in_stall_o / in_data_i) carries the filtered stream,
// one byte per beat: a filter-type byte, then row_bytes data bytes, per scanline.
// A beat with image_start set begins a new image. Output channel (out_valid_o /
// out_stall_i / out_data_o) carries one beat per data byte; a filter byte yields none.
// An unknown filter code yields one beat with error set, and every later byte is
// passed through with error set until the next image_start.
// Throughput is one byte per cycle while the receiver does not stall: the line store
// is read once when a byte is taken and written once when its result moves to the
// output register. A byte is registered in the reconstruction stage along with its
// line store read, then reconstructed into the output register.
// When the receiver stalls, the stage and the output register hold two results;
// in_stall_o rises only when both are full.
// Reset clears the control state, the neighbour histories and the registers
// (row_bytes = 1, bytes_per_pixel = 1). The line store is not cleared; the first
// row of each image never uses it. Write configuration only while idle.
module png_scanline_unfilter #(
  parameter int unsigned MAX_ROW_BYTES   = psu_pkg::MaxRowBytesDef,
  parameter int unsigned MAX_PIXEL_BYTES = psu_pkg::MaxPixelBytesDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [psu_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [psu_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  psu_pkg::in_t                 in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output psu_pkg::out_t                out_data_o
);

  localparam int unsigned ColW  = $clog2(MAX_ROW_BYTES + 1);
  localparam int unsigned PosW  = $clog2(MAX_ROW_BYTES);
  localparam int unsigned CmpW  = (ColW > psu_pkg::RowBytesW) ? ColW : psu_pkg::RowBytesW;
  localparam int unsigned PbW   = $clog2(MAX_PIXEL_BYTES + 1);
  localparam int unsigned SlotW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

  function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c);
    logic signed [9:0] db;
    logic signed [9:0] da;
    logic signed [9:0] dc;
    logic [9:0] pa;
    logic [9:0] pb;
    logic [9:0] pc;
    logic [7:0] res;
    // pa = |b - c|, pb = |a - c|, pc = |a + b - 2c|
    db = $signed({2'b00, b}) - $signed({2'b00, c});
    da = $signed({2'b00, a}) - $signed({2'b00, c});
    dc = da + db;
    pa = db[9] ? 10'(-db) : 10'(db);
    pb = da[9] ? 10'(-da) : 10'(da);
    pc = dc[9] ? 10'(-dc) : 10'(dc);
    if (pa <= pb && pa <= pc) begin
      res = a;
    end else if (pb <= pc) begin
      res = b;
    end else begin
      res = c;
    end
    return res;
  endfunction

  // Configuration registers.
  logic [psu_pkg::RowBytesW-1:0]   row_bytes_q;
  logic [psu_pkg::PixelBytesW-1:0] pixel_bytes_q;

  // Row control, updated when a byte is taken.
  logic [ColW-1:0]  col_q, col_d;
  logic [2:0]       kind_q, kind_d;
  logic             first_q, first_d;
  logic             err_q, err_d;
  logic [SlotW-1:0] mod_cnt_q [MAX_PIXEL_BYTES];
  logic [SlotW-1:0] mod_cnt_d [MAX_PIXEL_BYTES];

  // Reconstruction stage.
  logic             s1_valid_q, s1_valid_d;
  logic             s1_pass_q;
  logic [7:0]       s1_byte_q;
  logic [PosW-1:0]  s1_pos_q;
  logic [SlotW-1:0] s1_slot_q;
  logic             s1_left_q;
  logic             s1_first_q;
  logic [2:0]       s1_kind_q;
  logic             s1_last_q;

  // Neighbour histories and line store.
  logic [7:0] left_hist_q [MAX_PIXEL_BYTES];
  logic [7:0] top_hist_q  [MAX_PIXEL_BYTES];
  logic [7:0] line_mem    [MAX_ROW_BYTES];
  logic [7:0] line_rd_q;

  logic          out_valid_q;
  psu_pkg::out_t out_q;

  logic            accept, s1_adv;
  logic            start;
  logic [ColW-1:0] col_eff, rb_eff, col_inc;
  logic [CmpW-1:0] rb_ext;
  logic [PbW-1:0]  bpp_eff, bpp_m1;
  logic            err_eff, first_eff;
  logic            is_data, load_s1, load_pass, row_last;
  logic [PosW-1:0] pos;
  logic [SlotW-1:0] slot;
  logic            has_left;
  logic            wr_en;
  logic [7:0]      a_nb, b_nb, c_nb, pred, val;

  assign s1_adv     = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign accept     = in_valid_i && !in_stall_o;
  assign start      = in_data_i.image_start;

  // Register values outside their range are clamped.
  always_comb begin
    rb_ext = CmpW'(row_bytes_q);
    if (row_bytes_q == '0) begin
      rb_eff = ColW'(1);
    end else if (rb_ext > CmpW'(MAX_ROW_BYTES)) begin
      rb_eff = ColW'(MAX_ROW_BYTES);
    end else begin
      rb_eff = rb_ext[ColW-1:0];
    end
    if (pixel_bytes_q == '0) begin
      bpp_eff = PbW'(1);
    end else if (pixel_bytes_q > psu_pkg::PixelBytesW'(MAX_PIXEL_BYTES)) begin
      bpp_eff = PbW'(MAX_PIXEL_BYTES);
    end else begin
      bpp_eff = pixel_bytes_q[PbW-1:0];
    end
    bpp_m1 = bpp_eff - PbW'(1);
  end

  // Front end: filter-byte parsing, position tracking and the line store read.
  always_comb begin
    col_eff   = start ? '0 : col_q;
    err_eff   = start ? 1'b0 : err_q;
    first_eff = start ? 1'b1 : first_q;
    col_inc   = col_eff + ColW'(1);
    pos       = col_eff[PosW-1:0] - PosW'(1);
    slot      = mod_cnt_q[bpp_m1[SlotW-1:0]];
    has_left  = pos >= PosW'(bpp_eff);
    row_last  = col_eff >= rb_eff;
    is_data   = !err_eff && (col_eff != '0);
    load_pass = err_eff || ((col_eff == '0) && (in_data_i.data_byte > 8'd4));
    load_s1   = is_data || load_pass;

    col_d   = col_q;
    kind_d  = kind_q;
    first_d = first_q;
    err_d   = err_q;
    for (int i = 0; i < int'(MAX_PIXEL_BYTES); i++) begin
      mod_cnt_d[i] = mod_cnt_q[i];
    end
    if (accept) begin
      col_d   = col_eff;
      kind_d  = start ? 3'(psu_pkg::FILT_NONE) : kind_q;
      first_d = first_eff;
      err_d   = err_eff;
      if (load_pass) begin
        err_d = 1'b1;
      end else if (col_eff == '0) begin
        kind_d = in_data_i.data_byte[2:0];
        col_d  = ColW'(1);
        for (int i = 0; i < int'(MAX_PIXEL_BYTES); i++) begin
          mod_cnt_d[i] = '0;
        end
      end else begin
        col_d = row_last ? '0 : col_inc;
        if (row_last) begin
          first_d = 1'b0;
        end
        // One counter per pixel size keeps pos modulo that size.
        for (int i = 0; i < int'(MAX_PIXEL_BYTES); i++) begin
          mod_cnt_d[i] = (mod_cnt_q[i] == SlotW'(i)) ? '0 : mod_cnt_q[i] + SlotW'(1);
        end
      end
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept && load_s1) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_bytes_q   <= psu_pkg::RowBytesW'(1);
      pixel_bytes_q <= psu_pkg::PixelBytesW'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        psu_pkg::CFG_ROW_BYTES: begin
          row_bytes_q <= cfg_data_i[psu_pkg::RowBytesW-1:0];
        end
        psu_pkg::CFG_PIXEL_BYTES: begin
          pixel_bytes_q <= cfg_data_i[psu_pkg::PixelBytesW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      kind_q      <= 3'(psu_pkg::FILT_NONE);
      first_q     <= 1'b1;
      err_q       <= 1'b0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < int'(MAX_PIXEL_BYTES); i++) begin
        mod_cnt_q[i] <= '0;
      end
    end else begin
      col_q      <= col_d;
      kind_q     <= kind_d;
      first_q    <= first_d;
      err_q      <= err_d;
      s1_valid_q <= s1_valid_d;
      mod_cnt_q  <= mod_cnt_d;
      if (s1_adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && load_s1) begin
      s1_pass_q  <= load_pass;
      s1_byte_q  <= in_data_i.data_byte;
      s1_pos_q   <= pos;
      s1_slot_q  <= slot;
      s1_left_q  <= has_left;
      s1_first_q <= first_eff;
      s1_kind_q  <= kind_q & {3{!start}};
      s1_last_q  <= row_last;
    end
  end

  // Reconstruction from the neighbours a (left), b (up) and c (up-left).
  always_comb begin
    b_nb = s1_first_q ? 8'd0 : line_rd_q;
    a_nb = s1_left_q ? left_hist_q[s1_slot_q] : 8'd0;
    c_nb = (s1_left_q && !s1_first_q) ? top_hist_q[s1_slot_q] : 8'd0;
    case (s1_kind_q)
      psu_pkg::FILT_SUB:     pred = a_nb;
      psu_pkg::FILT_UP:      pred = b_nb;
      psu_pkg::FILT_AVERAGE: pred = 8'(({1'b0, a_nb} + {1'b0, b_nb}) >> 1);
      psu_pkg::FILT_PAETH:   pred = paeth(a_nb, b_nb, c_nb);
      default:               pred = 8'd0;
    endcase
    val   = s1_byte_q + pred;
    wr_en = s1_valid_q && s1_adv && !s1_pass_q;
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_valid_q) begin
      out_q.pixel_byte  <= s1_pass_q ? s1_byte_q : val;
      out_q.last_in_row <= s1_pass_q ? 1'b0 : s1_last_q;
      out_q.error       <= s1_pass_q;
    end
  end

  // A new image clears the histories; a leftover write of the old image loses.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(MAX_PIXEL_BYTES); i++) begin
        left_hist_q[i] <= '0;
        top_hist_q[i]  <= '0;
      end
    end else if (accept && start) begin
      for (int i = 0; i < int'(MAX_PIXEL_BYTES); i++) begin
        left_hist_q[i] <= '0;
        top_hist_q[i]  <= '0;
      end
    end else if (wr_en) begin
      left_hist_q[s1_slot_q] <= val;
      top_hist_q[s1_slot_q]  <= b_nb;
    end
  end

  // The line store is overwritten in place as the current row is produced.
  // A byte is taken only when the stage is free or moving on, and a filter
  // byte always separates two reads of the same entry, so a read never meets
  // a pending write to its own entry.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      line_mem[s1_pos_q] <= val;
    end
    if (accept && is_data) begin
      line_rd_q <= line_mem[pos];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTH
  a_no_rw_overlap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_data && wr_en) |-> (pos != s1_pos_q))
    else $error("line store read meets a pending write to the same entry");

  a_stall_only_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q))
    else $error("input stalled while a stage is free");

  a_col_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q <= ColW'(MAX_ROW_BYTES))
    else $error("column beyond the longest row");

  a_row_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_data && row_last) |=> (col_q == '0) && !first_q)
    else $error("row end did not return to the filter byte");

  a_err_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (err_q && !(accept && start)) |=> err_q)
    else $error("error flag dropped inside an image");
`endif

endmodule
